// File: sv/acu_pkg.sv
package acu_pkg;

  typedef enum logic [4:0] {
    OP_NOT = 5'd0,
    OP_BSL = 5'd1,
    OP_BSR = 5'd2,
    OP_BRL = 5'd3,
    OP_BRR = 5'd4,
    OP_PSH = 5'd5,
    OP_POP = 5'd6,
    OP_RET = 5'd7,
    OP_LDR = 5'd8,
    OP_STR = 5'd9,
    OP_ORR = 5'd10,
    OP_AND = 5'd11,
    OP_XOR = 5'd12,
    OP_ADD = 5'd13,
    OP_LDI = 5'd14,
    OP_LDM = 5'd15,
    OP_STM = 5'd16,
    OP_JMP = 5'd17,
    OP_JC0 = 5'd18,
    OP_JC1 = 5'd19,
    OP_JA0 = 5'd20,
    OP_JA1 = 5'd21,
    OP_CLL = 5'd22
  } op_t;

  localparam int unsigned NUM_REGS = 16;

  typedef struct packed {
    logic [4:0]  op;
    logic [3:0]  reg_index;
    logic [7:0]  operand_high;
    logic [7:0]  operand_low;
    logic [15:0] current_pc;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic        carry_out;
    logic [15:0] stack_out;
    logic [15:0] next_pc;
  } out_req_t;

endpackage

// File: sv/accumulator_cpu_execute_unit.sv
// Execute unit of an 8-bit accumulator machine. Each request on in_req is one decoded
// instruction; exactly one request leaves on out_req with the accumulator, carry, stack
// pointer and next PC after it. Data memory is a single-port, read-first synchronous RAM
// of 2**ADDR_BITS bytes, so its one port sets the cost per instruction: register, ALU,
// jump, push and store instructions need only PH_RUN; POP and LDM add PH_LOAD (read
// latency), CLL adds PH_CALL_LO (second stack write), RET adds PH_RET_LO and PH_RET_HI
// (two stack reads plus latency). After reset the unit sweeps every RAM address to zero,
// one byte a cycle, with in_ready low. The result sits in an output register, so a new
// instruction is taken while out_ready is high even if the previous result is still waiting.
module accumulator_cpu_execute_unit #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  acu_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output acu_pkg::out_req_t out_req
);

  localparam int unsigned MEM_DEPTH = 2 ** ADDR_BITS;

  typedef enum logic [2:0] {
    PH_CLEAR,
    PH_RUN,
    PH_LOAD,
    PH_RET_LO,
    PH_RET_HI,
    PH_CALL_LO
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [ADDR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]           acc_r, acc_nxt;
  logic [7:0]           prev_r, prev_nxt;
  logic                 carry_r, carry_nxt;
  logic [15:0]          sp_r, sp_nxt;
  logic [7:0]           rf_r [acu_pkg::NUM_REGS];
  logic                 rf_we;
  acu_pkg::in_req_t     hold_r, hold_nxt;
  logic [7:0]           ret_lo_r, ret_lo_nxt;
  logic                 out_valid_r, out_valid_nxt;
  acu_pkg::out_req_t    out_r, out_nxt;

  logic [7:0]           data_mem [MEM_DEPTH];
  logic [7:0]           mem_rdata_r;
  logic [15:0]          mem_addr16;
  logic [ADDR_BITS-1:0] mem_addr;
  logic                 mem_we;
  logic [7:0]           mem_wdata;

  logic                 in_fire;
  logic [7:0]           rf_val;
  logic [8:0]           sum9;
  logic [15:0]          target;
  logic [15:0]          npc;

  assign in_ready  = (phase_r == PH_RUN) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_req   = out_r;

  assign rf_val   = rf_r[in_req.reg_index];
  assign sum9     = {1'b0, acc_r} + {1'b0, rf_val};
  assign target   = {in_req.operand_high, in_req.operand_low};
  assign mem_addr = mem_addr16[ADDR_BITS-1:0];

  always_comb begin
    phase_nxt     = phase_r;
    clr_cnt_nxt   = clr_cnt_r;
    acc_nxt       = acc_r;
    prev_nxt      = prev_r;
    carry_nxt     = carry_r;
    sp_nxt        = sp_r;
    hold_nxt      = hold_r;
    ret_lo_nxt    = ret_lo_r;
    rf_we         = 1'b0;
    mem_addr16    = sp_r;
    mem_we        = 1'b0;
    mem_wdata     = 8'h00;
    npc           = in_req.current_pc;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (phase_r)
      PH_CLEAR: begin
        mem_addr16  = 16'(clr_cnt_r);
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          phase_nxt = PH_RUN;
        end
      end
      PH_RUN: begin
        if (in_fire) begin
          hold_nxt = in_req;
          case (in_req.op)
            acu_pkg::OP_NOT: begin
              prev_nxt = acc_r;
              acc_nxt  = ~acc_r;
            end
            acu_pkg::OP_BSL: begin
              prev_nxt = acc_r;
              acc_nxt  = {acc_r[6:0], 1'b0};
            end
            acu_pkg::OP_BSR: begin
              prev_nxt = acc_r;
              acc_nxt  = {1'b0, acc_r[7:1]};
            end
            acu_pkg::OP_BRL: begin
              prev_nxt = acc_r;
              acc_nxt  = {acc_r[6:0], acc_r[7]};
            end
            acu_pkg::OP_BRR: begin
              prev_nxt = acc_r;
              acc_nxt  = {acc_r[0], acc_r[7:1]};
            end
            acu_pkg::OP_PSH: begin
              sp_nxt     = sp_r - 16'd1;
              mem_addr16 = sp_r - 16'd1;
              mem_we     = 1'b1;
              mem_wdata  = acc_r;
            end
            acu_pkg::OP_POP: begin
              mem_we    = 1'b1;
              sp_nxt    = sp_r + 16'd1;
              phase_nxt = PH_LOAD;
            end
            acu_pkg::OP_RET: begin
              mem_we    = 1'b1;
              sp_nxt    = sp_r + 16'd1;
              phase_nxt = PH_RET_LO;
            end
            acu_pkg::OP_LDR: acc_nxt = rf_val;
            acu_pkg::OP_STR: rf_we = 1'b1;
            acu_pkg::OP_ORR: begin
              prev_nxt = acc_r;
              acc_nxt  = acc_r | rf_val;
            end
            acu_pkg::OP_AND: begin
              prev_nxt = acc_r;
              acc_nxt  = acc_r & rf_val;
            end
            acu_pkg::OP_XOR: begin
              prev_nxt = acc_r;
              acc_nxt  = acc_r ^ rf_val;
            end
            acu_pkg::OP_ADD: begin
              prev_nxt  = acc_r;
              acc_nxt   = sum9[7:0];
              carry_nxt = sum9[8];
            end
            acu_pkg::OP_LDI: acc_nxt = in_req.operand_high;
            acu_pkg::OP_LDM: begin
              mem_addr16 = target;
              phase_nxt  = PH_LOAD;
            end
            acu_pkg::OP_STM: begin
              mem_addr16 = target;
              mem_we     = 1'b1;
              mem_wdata  = acc_r;
            end
            acu_pkg::OP_JMP: npc = target;
            acu_pkg::OP_JC0: if (!carry_r) npc = target;
            acu_pkg::OP_JC1: if (carry_r) npc = target;
            acu_pkg::OP_JA0: if (acc_r == 8'h00) npc = target;
            acu_pkg::OP_JA1: if (acc_r != 8'h00) npc = target;
            acu_pkg::OP_CLL: begin
              sp_nxt     = sp_r - 16'd1;
              mem_addr16 = sp_r - 16'd1;
              mem_we     = 1'b1;
              mem_wdata  = in_req.current_pc[15:8];
              phase_nxt  = PH_CALL_LO;
            end
            default: ;
          endcase
          if (phase_nxt == PH_RUN) begin
            out_nxt       = '{acc_out: acc_nxt, carry_out: carry_nxt,
                              stack_out: sp_nxt, next_pc: npc};
            out_valid_nxt = 1'b1;
          end
        end
      end
      PH_LOAD: begin
        acc_nxt       = mem_rdata_r;
        out_nxt       = '{acc_out: mem_rdata_r, carry_out: carry_r,
                          stack_out: sp_r, next_pc: hold_r.current_pc};
        out_valid_nxt = 1'b1;
        phase_nxt     = PH_RUN;
      end
      PH_RET_LO: begin
        mem_we     = 1'b1;
        sp_nxt     = sp_r + 16'd1;
        ret_lo_nxt = mem_rdata_r;
        phase_nxt  = PH_RET_HI;
      end
      PH_RET_HI: begin
        out_nxt       = '{acc_out: acc_r, carry_out: carry_r,
                          stack_out: sp_r, next_pc: {mem_rdata_r, ret_lo_r}};
        out_valid_nxt = 1'b1;
        phase_nxt     = PH_RUN;
      end
      PH_CALL_LO: begin
        sp_nxt        = sp_r - 16'd1;
        mem_addr16    = sp_r - 16'd1;
        mem_we        = 1'b1;
        mem_wdata     = hold_r.current_pc[7:0];
        out_nxt       = '{acc_out: acc_r, carry_out: carry_r, stack_out: sp_r - 16'd1,
                          next_pc: {hold_r.operand_high, hold_r.operand_low}};
        out_valid_nxt = 1'b1;
        phase_nxt     = PH_RUN;
      end
      default: phase_nxt = PH_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CLEAR;
      clr_cnt_r   <= '0;
      acc_r       <= 8'h00;
      prev_r      <= 8'h00;
      carry_r     <= 1'b0;
      sp_r        <= 16'h0000;
      out_valid_r <= 1'b0;
      for (int i = 0; i < acu_pkg::NUM_REGS; i++) begin
        rf_r[i] <= 8'h00;
      end
    end else begin
      phase_r     <= phase_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      acc_r       <= acc_nxt;
      prev_r      <= prev_nxt;
      carry_r     <= carry_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (rf_we) begin
        rf_r[in_req.reg_index] <= acc_r;
      end
    end
    hold_r   <= hold_nxt;
    ret_lo_r <= ret_lo_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      data_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= data_mem[mem_addr];
  end

  a_load_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req.op == acu_pkg::OP_POP || in_req.op == acu_pkg::OP_LDM)
    |=> !in_ready && !out_valid)
    else $error("read instruction did not stall for memory latency");

  a_ret_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req.op == acu_pkg::OP_RET |=> !in_ready ##1 !in_ready)
    else $error("return did not take both stack reads");

  a_call_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req.op == acu_pkg::OP_CLL |=> !in_ready && mem_we)
    else $error("call did not write its second stack byte");

  a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req.op == acu_pkg::OP_PSH
    |=> out_valid && out_req.stack_out == $past(sp_r) - 16'd1)
    else $error("push result has wrong stack pointer");

endmodule
